/* design/ers_pkg.sv */
package ers_pkg;

	// default floor count
	localparam int FLOORS_DEF = 4;

	// item operation codes
	typedef enum logic [1:0] {
		MODE_PRESS       = 2'd0,
		MODE_CLEAR_FLOOR = 2'd1,
		MODE_CLEAR_ALL   = 2'd2,
		MODE_QUERY       = 2'd3
	} mode_t;

	// button codes
	localparam logic [1:0] BTN_HALL_UP   = 2'd0;
	localparam logic [1:0] BTN_HALL_DOWN = 2'd1;
	localparam logic [1:0] BTN_CAB       = 2'd2;

	// direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// bit positions inside one floor's call row
	localparam int CALL_UP_BIT   = 0;
	localparam int CALL_DOWN_BIT = 1;
	localparam int CALL_CAB_BIT  = 2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_UPDATE = 2'd1,
		ST_SCAN   = 2'd2,
		ST_DONE   = 2'd3
	} state_t;

	// one captured request
	typedef struct packed {
		mode_t      mode;
		logic [1:0] floor;
		logic [1:0] button;
		logic [1:0] travel_direction;
		logic [1:0] last_floor;
		logic       between_floors;
		logic [1:0] last_moved_direction;
	} item_t;

	// update command from sequencer to call store
	typedef struct packed {
		logic       apply;
		mode_t      mode;
		logic [1:0] floor;
		logic [1:0] button;
	} upd_t;

	// decision handed to the output register
	typedef struct packed {
		logic       should_stop;
		logic [1:0] next_direction;
	} res_t;

	// reverse a travel direction, stop and unknown codes give stop
	function automatic logic [1:0] reverse_dir(input logic [1:0] d);
		logic [1:0] r;
		case (d)
			DIR_UP:   r = DIR_DOWN;
			DIR_DOWN: r = DIR_UP;
			default:  r = DIR_STOP;
		endcase
		return r;
	endfunction

endpackage

/* design/ers_call_store.sv */
module ers_call_store import ers_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  upd_t                      upd,
	input  logic [$clog2(FLOORS)-1:0] scan_idx,
	output logic [2:0]                scan_row
);

	localparam int IDX_W = $clog2(FLOORS);
	localparam int CMP_W = ($clog2(FLOORS + 1) > 2) ? $clog2(FLOORS + 1) : 2;

	logic [2:0]       rows_q [FLOORS];
	logic             floor_ok;
	logic [IDX_W-1:0] floor_idx;
	logic             top_floor;

	// address decode of the update
	assign floor_ok  = CMP_W'(upd.floor) < CMP_W'(FLOORS);
	assign floor_idx = IDX_W'(upd.floor);
	assign top_floor = floor_idx == IDX_W'(FLOORS - 1);

	// call matrix, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLOORS; i++) begin
				rows_q[i] <= '0;
			end
		end else if (upd.apply) begin
			case (upd.mode)
				MODE_PRESS: begin
					if (floor_ok) begin
						if (upd.button == BTN_HALL_UP && !top_floor) begin
							rows_q[floor_idx][CALL_UP_BIT] <= 1'b1;
						end else if (upd.button == BTN_HALL_DOWN && upd.floor != 2'd0) begin
							rows_q[floor_idx][CALL_DOWN_BIT] <= 1'b1;
						end else if (upd.button == BTN_CAB) begin
							rows_q[floor_idx][CALL_CAB_BIT] <= 1'b1;
						end
					end
				end
				MODE_CLEAR_FLOOR: begin
					if (floor_ok) begin
						rows_q[floor_idx] <= '0;
					end
				end
				MODE_CLEAR_ALL: begin
					for (int i = 0; i < FLOORS; i++) begin
						rows_q[i] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// scan read port
	assign scan_row = rows_q[scan_idx];

endmodule

/* design/ers_seq.sv */
module ers_seq import ers_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  item_t                     item,
	input  logic [2:0]                scan_row,
	output logic [$clog2(FLOORS)-1:0] scan_idx,
	output upd_t                      upd,
	output logic                      busy,
	output logic                      done,
	output res_t                      res
);

	localparam int IDX_W = $clog2(FLOORS);
	localparam int CMP_W = ($clog2(FLOORS + 1) > 2) ? $clog2(FLOORS + 1) : 2;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOORS - 1);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             clr_acc, scan_en;

	// accumulated scan results
	logic       above_f_q, below_f_q, above_l_q, below_l_q, at_l_q;
	logic [2:0] row_f_q;

	logic [CMP_W-1:0] idx_c, floor_c, last_c, last_sat;
	logic             row_any;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_SCAN;
			ST_SCAN:   if (idx_q == LAST_IDX) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy    = 1'b1;
		clr_acc = 1'b0;
		scan_en = 1'b0;
		done    = 1'b0;
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_UPDATE: clr_acc = 1'b1;
			ST_SCAN:   scan_en = 1'b1;
			ST_DONE:   done = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_acc) begin
				idx_q <= '0;
			end else if (scan_en && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// update command goes out in the update slot
	assign upd.apply  = clr_acc;
	assign upd.mode   = item.mode;
	assign upd.floor  = item.floor;
	assign upd.button = item.button;
	assign scan_idx   = idx_q;

	// shared compare unit: one floor per cycle against the request floor and last floor
	assign idx_c    = CMP_W'(idx_q);
	assign floor_c  = CMP_W'(item.floor);
	assign last_c   = CMP_W'(item.last_floor);
	assign last_sat = (last_c >= CMP_W'(FLOORS)) ? CMP_W'(FLOORS - 1) : last_c;
	assign row_any  = |scan_row;

	always_ff @(posedge clk) begin
		if (clr_acc) begin
			above_f_q <= 1'b0;
			below_f_q <= 1'b0;
			above_l_q <= 1'b0;
			below_l_q <= 1'b0;
			at_l_q    <= 1'b0;
			row_f_q   <= '0;
		end else if (scan_en) begin
			if (idx_c > floor_c && row_any) above_f_q <= 1'b1;
			if (idx_c < floor_c && row_any) below_f_q <= 1'b1;
			if (idx_c == floor_c) row_f_q <= scan_row;
			if (idx_c > last_sat && row_any) above_l_q <= 1'b1;
			if (idx_c < last_sat && row_any) below_l_q <= 1'b1;
			if (idx_c == last_sat) at_l_q <= row_any;
		end
	end

	// stop decision for the request floor
	always_comb begin
		res.should_stop = row_f_q[CALL_CAB_BIT];
		case (item.travel_direction)
			DIR_UP: begin
				if (row_f_q[CALL_UP_BIT] || (!above_f_q && row_f_q[CALL_DOWN_BIT]))
					res.should_stop = 1'b1;
			end
			DIR_DOWN: begin
				if (row_f_q[CALL_DOWN_BIT] || (!below_f_q && row_f_q[CALL_UP_BIT]))
					res.should_stop = 1'b1;
			end
			DIR_STOP: begin
				if (|row_f_q) res.should_stop = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// next direction seen from the last floor
	always_comb begin
		if (item.between_floors && at_l_q) begin
			res.next_direction = reverse_dir(item.last_moved_direction);
		end else if (item.travel_direction == DIR_DOWN) begin
			res.next_direction = below_l_q ? DIR_DOWN : (above_l_q ? DIR_UP : DIR_STOP);
		end else begin
			res.next_direction = above_l_q ? DIR_UP : (below_l_q ? DIR_DOWN : DIR_STOP);
		end
	end

	// scan walks the floors one at a time
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q != LAST_IDX) |=>
		(state_q == ST_SCAN && idx_q == IDX_W'($past(idx_q) + 1'b1)))
		else $error("scan index did not advance");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && idx_q == LAST_IDX) |=> state_q == ST_DONE)
		else $error("scan did not finish after last floor");

	a_update_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("scan did not start at floor zero");

endmodule

/* design/elevator_request_scheduler.sv */
// Elevator collective-control request scheduler.
// Request channel: a request is taken at a rising edge with start high and
// busy low; mode, floor, button, travel_direction, last_floor,
// between_floors and last_moved_direction are sampled at that edge.
// Each request first updates the pending-call matrix (press, clear one floor,
// clear all, or nothing), then reports should_stop for the given floor and
// next_direction seen from the last known floor.
// Result channel: done is high for exactly one cycle with should_stop and
// next_direction valid; the receiver takes it at the edge ending that cycle
// and cannot stall it.
// busy stays high while the sequencer is in its update, scan and done states,
// so a new request is taken only once the current one has left its scan; the
// scan of the call matrix runs through one shared compare unit, one floor per cycle.
// Reset (arst_n low) clears all pending calls, returns the sequencer to idle
// and drops done.
module elevator_request_scheduler import ers_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [1:0] floor,
	input  logic [1:0] button,
	input  logic [1:0] travel_direction,
	input  logic [1:0] last_floor,
	input  logic       between_floors,
	input  logic [1:0] last_moved_direction,
	output logic       done,
	output logic       should_stop,
	output logic [1:0] next_direction
);

	localparam int IDX_W = $clog2(FLOORS);

	item_t            item_q;
	logic             accept;
	upd_t             upd;
	logic [IDX_W-1:0] scan_idx;
	logic [2:0]       scan_row;
	logic             seq_done;
	res_t             res;
	logic             done_q;
	logic             should_stop_q;
	logic [1:0]       next_direction_q;

	assign accept = start && !busy;

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.mode                 <= mode_t'(mode);
			item_q.floor                <= floor;
			item_q.button               <= button;
			item_q.travel_direction     <= travel_direction;
			item_q.last_floor           <= last_floor;
			item_q.between_floors       <= between_floors;
			item_q.last_moved_direction <= last_moved_direction;
		end
	end

	ers_call_store #(.FLOORS(FLOORS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.scan_idx (scan_idx),
		.scan_row (scan_row)
	);

	ers_seq #(.FLOORS(FLOORS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item_q),
		.scan_row (scan_row),
		.scan_idx (scan_idx),
		.upd      (upd),
		.busy     (busy),
		.done     (seq_done),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= seq_done;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			should_stop_q    <= res.should_stop;
			next_direction_q <= res.next_direction;
		end
	end

	assign done           = done_q;
	assign should_stop    = should_stop_q;
	assign next_direction = next_direction_q;

	// results never come in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// busy rises only after a taken request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// reported direction is always a legal code
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (next_direction == DIR_STOP || next_direction == DIR_UP ||
			next_direction == DIR_DOWN))
		else $error("illegal next direction reported");

endmodule

/* bench/tb.sv */
module tb import ers_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FLOORS = FLOORS_DEF;
	localparam int RANDOM_REQUESTS = 900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * (FLOORS + 3) + 10;

	typedef struct packed {
		logic       stop;
		logic [1:0] dir;
	} decision_t;

	typedef struct packed {
		item_t     req;
		logic      typed;
		decision_t want;
	} plan_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] mode = MODE_QUERY;
	logic [1:0] floor = 2'd0;
	logic [1:0] button = BTN_CAB;
	logic [1:0] travel_direction = DIR_STOP;
	logic [1:0] last_floor = 2'd0;
	logic       between_floors = 1'b0;
	logic [1:0] last_moved_direction = DIR_STOP;
	logic       done;
	logic       should_stop;
	logic [1:0] next_direction;

	// predicted call matrix and decisions still owed by the block
	logic [2:0] call_rows [FLOORS];
	decision_t  decision_q [$];
	int         fail_count = 0;
	int         cycle_count = 0;

	elevator_request_scheduler #(.FLOORS(FLOORS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.floor(floor),
		.button(button),
		.travel_direction(travel_direction),
		.last_floor(last_floor),
		.between_floors(between_floors),
		.last_moved_direction(last_moved_direction),
		.done(done),
		.should_stop(should_stop),
		.next_direction(next_direction)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
	endtask

	// call matrix queries
	function automatic bit has_above(input int f);
		for (int s = f + 1; s < FLOORS; s++)
			if (call_rows[s] != '0)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic bit has_below(input int f);
		for (int s = 0; s < f && s < FLOORS; s++)
			if (call_rows[s] != '0)
				return 1'b1;
		return 1'b0;
	endfunction

	// apply one request to the call matrix
	function automatic void apply_update(input item_t r);
		int f;
		f = r.floor;
		case (r.mode)
			MODE_PRESS: begin
				if (f < FLOORS) begin
					if (r.button == BTN_HALL_UP && f + 1 < FLOORS)
						call_rows[f][CALL_UP_BIT] = 1'b1;
					else if (r.button == BTN_HALL_DOWN && f > 0)
						call_rows[f][CALL_DOWN_BIT] = 1'b1;
					else if (r.button == BTN_CAB)
						call_rows[f][CALL_CAB_BIT] = 1'b1;
				end
			end
			MODE_CLEAR_FLOOR: begin
				if (f < FLOORS)
					call_rows[f] = '0;
			end
			MODE_CLEAR_ALL: begin
				foreach (call_rows[i])
					call_rows[i] = '0;
			end
			default: ;
		endcase
	endfunction

	// stop decision at the request floor
	function automatic logic stop_decision(input int f, input logic [1:0] d);
		logic [2:0] c;
		logic       s;
		if (f >= FLOORS)
			return 1'b0;
		c = call_rows[f];
		if (c[CALL_CAB_BIT])
			return 1'b1;
		case (d)
			DIR_UP:   s = c[CALL_UP_BIT] || (!has_above(f) && c[CALL_DOWN_BIT]);
			DIR_DOWN: s = c[CALL_DOWN_BIT] || (!has_below(f) && c[CALL_UP_BIT]);
			DIR_STOP: s = (c != '0);
			default:  s = 1'b0;
		endcase
		return s;
	endfunction

	// next direction from the last known floor
	function automatic logic [1:0] direction_choice(input item_t r);
		int f;
		f = r.last_floor;
		if (f >= FLOORS)
			f = FLOORS - 1;
		// car between floors with calls waiting behind it turns around
		if (r.between_floors && call_rows[f] != '0) begin
			if (r.last_moved_direction == DIR_UP)
				return DIR_DOWN;
			if (r.last_moved_direction == DIR_DOWN)
				return DIR_UP;
			return DIR_STOP;
		end
		if (r.travel_direction == DIR_DOWN) begin
			if (has_below(f))
				return DIR_DOWN;
			if (has_above(f))
				return DIR_UP;
			return DIR_STOP;
		end
		if (has_above(f))
			return DIR_UP;
		if (has_below(f))
			return DIR_DOWN;
		return DIR_STOP;
	endfunction

	function automatic plan_row_t row(input mode_t m, input logic [1:0] f, input logic [1:0] b,
			input logic [1:0] td, input logic [1:0] lf, input logic bf, input logic [1:0] ld,
			input logic typed, input logic st, input logic [1:0] nd);
		plan_row_t p;
		p.req.mode = m;
		p.req.floor = f;
		p.req.button = b;
		p.req.travel_direction = td;
		p.req.last_floor = lf;
		p.req.between_floors = bf;
		p.req.last_moved_direction = ld;
		p.typed = typed;
		p.want.stop = st;
		p.want.dir = nd;
		return p;
	endfunction

	function automatic item_t random_request();
		item_t r;
		int    p;
		p = $urandom_range(0, 99);
		if (p < 50)
			r.mode = MODE_PRESS;
		else if (p < 65)
			r.mode = MODE_CLEAR_FLOOR;
		else if (p < 70)
			r.mode = MODE_CLEAR_ALL;
		else
			r.mode = MODE_QUERY;
		r.floor = 2'($urandom_range(0, 3));
		r.button = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		r.travel_direction = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		r.last_floor = 2'($urandom_range(0, 3));
		r.between_floors = 1'($urandom_range(0, 1));
		r.last_moved_direction = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		return r;
	endfunction

	// drive one request, wait for it to be taken, then predict its decision
	task automatic send_request(input item_t r, input logic typed, input decision_t given);
		decision_t calc;
		mode <= r.mode;
		floor <= r.floor;
		button <= r.button;
		travel_direction <= r.travel_direction;
		last_floor <= r.last_floor;
		between_floors <= r.between_floors;
		last_moved_direction <= r.last_moved_direction;
		if (!start)
			start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_update(r);
		calc.stop = stop_decision(r.floor, r.travel_direction);
		calc.dir = direction_choice(r);
		decision_q.push_back(typed ? given : calc);
	endtask

	// sender idle time, mostly short with a few long pauses
	task automatic sender_gap(input bit steady);
		int n;
		int p;
		if (steady)
			return;
		p = $urandom_range(0, 99);
		if (p < 55)
			n = 0;
		else if (p < 90)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every pending decision has come back
	task automatic drain();
		if (start)
			start <= 1'b0;
		while (decision_q.size() != 0)
			@(posedge clk);
	endtask

	// result check
	always @(posedge clk) begin : result_check
		decision_t want;
		if (arst_n && done) begin
			if (decision_q.size() == 0) begin
				flag_mismatch("unexpected result, should_stop", should_stop, 0);
			end else begin
				want = decision_q.pop_front();
				if (should_stop !== want.stop)
					flag_mismatch("should_stop", should_stop, want.stop);
				if (next_direction !== want.dir)
					flag_mismatch("next_direction", next_direction, want.dir);
			end
		end
	end

	// stimulus
	initial begin : stimulus
		plan_row_t plan [$];
		bit        steady;
		foreach (call_rows[i])
			call_rows[i] = '0;
		steady = 1'b0;

		// empty matrix, ignored presses, then a first cab call
		plan.push_back(row(MODE_QUERY, 2'd0, BTN_CAB, DIR_STOP, 2'd0, 1'b0, DIR_STOP,
			1'b1, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd3, BTN_HALL_UP, DIR_UP, 2'd3, 1'b0, DIR_UP,
			1'b1, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd0, BTN_HALL_DOWN, DIR_DOWN, 2'd0, 1'b0, DIR_DOWN,
			1'b1, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd2, 2'd3, DIR_STOP, 2'd1, 1'b0, DIR_STOP,
			1'b1, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd3, BTN_CAB, DIR_UP, 2'd0, 1'b0, DIR_UP,
			1'b1, 1'b1, DIR_UP));
		// build up calls, two with an unknown travel direction
		plan.push_back(row(MODE_PRESS, 2'd0, BTN_HALL_UP, DIR_DOWN, 2'd3, 1'b0, DIR_DOWN,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd3, BTN_HALL_DOWN, DIR_UP, 2'd1, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd1, BTN_HALL_UP, 2'd3, 2'd2, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd2, BTN_CAB, 2'd3, 2'd2, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		// between floors with calls at the last floor
		plan.push_back(row(MODE_QUERY, 2'd2, BTN_CAB, DIR_UP, 2'd2, 1'b1, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_QUERY, 2'd1, BTN_CAB, DIR_DOWN, 2'd2, 1'b1, DIR_STOP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_QUERY, 2'd1, BTN_CAB, DIR_UP, 2'd2, 1'b1, 2'd3,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_QUERY, 2'd3, BTN_CAB, DIR_DOWN, 2'd3, 1'b1, DIR_DOWN,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd2, BTN_HALL_DOWN, DIR_DOWN, 2'd1, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		// clears
		plan.push_back(row(MODE_CLEAR_FLOOR, 2'd2, BTN_CAB, DIR_UP, 2'd2, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_CLEAR_FLOOR, 2'd0, BTN_CAB, DIR_STOP, 2'd1, 1'b1, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_QUERY, 2'd3, BTN_CAB, DIR_STOP, 2'd0, 1'b0, DIR_STOP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_CLEAR_ALL, 2'd1, BTN_CAB, DIR_UP, 2'd1, 1'b1, DIR_DOWN,
			1'b1, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_QUERY, 2'd3, BTN_CAB, DIR_DOWN, 2'd3, 1'b0, DIR_DOWN,
			1'b1, 1'b0, DIR_STOP));
		// collective rules going up and down
		plan.push_back(row(MODE_PRESS, 2'd0, BTN_CAB, DIR_STOP, 2'd0, 1'b0, DIR_STOP,
			1'b1, 1'b1, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd2, BTN_HALL_UP, DIR_UP, 2'd0, 1'b0, DIR_UP,
			1'b1, 1'b1, DIR_UP));
		plan.push_back(row(MODE_PRESS, 2'd1, BTN_HALL_DOWN, DIR_UP, 2'd0, 1'b0, DIR_UP,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_PRESS, 2'd1, BTN_HALL_DOWN, DIR_DOWN, 2'd3, 1'b0, DIR_DOWN,
			1'b0, 1'b0, DIR_STOP));
		// fields other than mode at their maximum; the first row presses hall up
		plan.push_back(row(MODE_PRESS, 2'd3, BTN_HALL_UP, 2'd3, 2'd3, 1'b1, 2'd3,
			1'b0, 1'b0, DIR_STOP));
		plan.push_back(row(MODE_CLEAR_ALL, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 2'd3,
			1'b1, 1'b0, DIR_STOP));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_request(plan[i].req, plan[i].typed, plan[i].want);
			sender_gap(1'b0);
		end
		drain();

		// random requests, with back-to-back stretches and full drains
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 100 == 0)
				steady = ($urandom_range(0, 3) == 0);
			send_request(random_request(), 1'b0, '0);
			sender_gap(steady);
			if (i % 150 == 149)
				drain();
		end

		if (start)
			start <= 1'b0;
		while (decision_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
design/ers_pkg.sv
design/ers_call_store.sv
design/ers_seq.sv
design/elevator_request_scheduler.sv
bench/tb.sv
